FILE: hw/rtl/cwc_pkg.sv
// Package: types, constants and character-class helpers for the whitespace collapser.
`timescale 1ns / 1ps

package cwc_pkg;

  // Code unit width and the stream byte width that holds it
  localparam int CHAR_W      = 16;
  localparam int TDATA_W     = ((CHAR_W + 7) / 8) * 8;
  localparam int RBUF_DEPTH  = 4;
  localparam int RBUF_AW     = $clog2(RBUF_DEPTH);
  localparam int RBUF_CW     = $clog2(RBUF_DEPTH + 1);

  // Special code units
  localparam logic [CHAR_W-1:0] CH_BSLASH = CHAR_W'(8'h5C);
  localparam logic [CHAR_W-1:0] CH_DQUOTE = CHAR_W'(8'h22);
  localparam logic [CHAR_W-1:0] CH_SQUOTE = CHAR_W'(8'h27);
  localparam logic [CHAR_W-1:0] CH_SPACE  = CHAR_W'(8'h20);

  // Literal tracking mode
  typedef enum logic [1:0] {
    LIT_NONE   = 2'd0,
    LIT_DOUBLE = 2'd1,
    LIT_SINGLE = 2'd2,
    LIT_TENT   = 2'd3
  } lit_mode_t;

  // Scanner state carried from one code unit to the next
  typedef struct packed {
    lit_mode_t mode;
    logic      esc;
    logic      sp;
    logic      started;
    logic      prev_alnum;
    logic      in_run;
    logic      run_digit;
  } cwc_state_t;

  localparam cwc_state_t STATE_RST = '{mode: LIT_NONE, default: 1'b0};

  // One result item
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              has_char;
    logic              run_last;
    logic              text_end;
  } cwc_res_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_W'(8'h30)) && (c <= CHAR_W'(8'h39));
  endfunction

  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    return is_digit(c) ||
           ((c >= CHAR_W'(8'h41)) && (c <= CHAR_W'(8'h5A))) ||
           ((c >= CHAR_W'(8'h61)) && (c <= CHAR_W'(8'h7A)));
  endfunction

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CHAR_W'(8'h09)) && (c <= CHAR_W'(8'h0D)));
  endfunction

endpackage

FILE: hw/rtl/code_whitespace_collapser.sv
// Top level: source text whitespace collapser with literal and digit-separator tracking.
//
//   Channel | Direction | tdata            | tuser                    | tlast
//   in_     | slave     | [15:0] char_in   | -                        | text_last
//   out_    | master    | [15:0] char_out  | [0] has_char [1] run_last| text_end
//
// One unit per cycle while the queue has room: it sits in the input register, the
// decision logic writes its 0, 1 or 2 results into a four-entry result queue.
// Output rate is one result per cycle while out_tready is high, so items giving two
// results slow input. in_tready depends on registered state only, never on out_tready.
// rst_n (synchronous) clears scanner state, the input stage and the queue.
`timescale 1ns / 1ps

module code_whitespace_collapser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [cwc_pkg::TDATA_W-1:0] in_tdata,   // [15:0] char_in
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [cwc_pkg::TDATA_W-1:0] out_tdata,  // [15:0] char_out
  output logic [1:0]                  out_tuser,  // [0] has_char, [1] run_last
  output logic                        out_tlast
);

  logic                       in_vld_r;
  logic [cwc_pkg::CHAR_W-1:0] in_char_r;
  logic                       in_last_r;
  cwc_pkg::cwc_state_t        st_r, st_nxt;
  cwc_pkg::cwc_res_t          res0, res1, q;
  logic [1:0]                 nres;
  logic                       room2;
  logic                       advance;

  assign advance   = in_vld_r && room2;
  assign in_tready = !in_vld_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata[cwc_pkg::CHAR_W-1:0];
      in_last_r <= in_tlast;
    end
  end

  // Decision logic
  cwc_step u_step (
    .st_i   (st_r),
    .char_i (in_char_r),
    .last_i (in_last_r),
    .st_o   (st_nxt),
    .res0_o (res0),
    .res1_o (res1),
    .nres_o (nres)
  );

  // Scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= cwc_pkg::STATE_RST;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Result queue
  cwc_rbuf u_rbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_n_i (advance ? nres : 2'd0),
    .d0_i     (res0),
    .d1_i     (res1),
    .room2_o  (room2),
    .vld_o    (out_tvalid),
    .pop_i    (out_tready),
    .q_o      (q)
  );

  assign out_tdata = cwc_pkg::TDATA_W'(q.ch);
  assign out_tuser = {q.run_last, q.has_char};
  assign out_tlast = q.text_end;

`ifndef SYNTHESIS
  // A bare end marker is always the text end
  a_bare_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> out_tlast)
    else $error("bare end marker without text end");

  // Text end is always the last result of its unit
  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tuser[1])
    else $error("text end without run last");

  // State returns to reset after the final unit of a text
  a_reset_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_last_r) |=> (st_r == cwc_pkg::STATE_RST))
    else $error("scanner state not cleared after text end");
`endif

endmodule

FILE: hw/rtl/cwc_step.sv
// Module: per-unit decision logic, next scanner state and up to two results.
`timescale 1ns / 1ps

module cwc_step (
  input  cwc_pkg::cwc_state_t        st_i,
  input  logic [cwc_pkg::CHAR_W-1:0] char_i,
  input  logic                       last_i,
  output cwc_pkg::cwc_state_t        st_o,
  output cwc_pkg::cwc_res_t          res0_o,
  output cwc_pkg::cwc_res_t          res1_o,
  output logic [1:0]                 nres_o
);

  always_comb begin
    cwc_pkg::cwc_state_t nst;
    cwc_pkg::lit_mode_t  mode;
    logic                alnum;
    logic                emit_sp;
    logic                emit_ch;

    nst     = st_i;
    alnum   = cwc_pkg::is_alnum(char_i);
    emit_sp = 1'b0;
    emit_ch = 1'b0;

    // Settle a tentative quote on this unit
    mode = st_i.mode;
    if (mode == cwc_pkg::LIT_TENT) begin
      mode = alnum ? cwc_pkg::LIT_NONE : cwc_pkg::LIT_SINGLE;
    end
    nst.mode = mode;

    // Literal copy, whitespace collapse or plain unit
    if ((mode == cwc_pkg::LIT_DOUBLE) || (mode == cwc_pkg::LIT_SINGLE)) begin
      emit_ch = 1'b1;
      if (st_i.esc) begin
        nst.esc = 1'b0;
      end else if (char_i == cwc_pkg::CH_BSLASH) begin
        nst.esc = !last_i;
      end else if (char_i == ((mode == cwc_pkg::LIT_DOUBLE) ? cwc_pkg::CH_DQUOTE
                                                             : cwc_pkg::CH_SQUOTE)) begin
        nst.mode = cwc_pkg::LIT_NONE;
      end
    end else if (cwc_pkg::is_space(char_i)) begin
      nst.sp = 1'b1;
    end else begin
      emit_sp = st_i.sp && st_i.started;
      emit_ch = 1'b1;
      nst.sp  = 1'b0;
      if (char_i == cwc_pkg::CH_DQUOTE) begin
        nst.mode = cwc_pkg::LIT_DOUBLE;
      end else if (char_i == cwc_pkg::CH_SQUOTE) begin
        nst.mode = (st_i.prev_alnum && st_i.run_digit && !last_i) ? cwc_pkg::LIT_TENT
                                                                   : cwc_pkg::LIT_SINGLE;
      end
    end
    if (emit_ch) begin
      nst.started = 1'b1;
    end

    // Run tracking follows every unit
    if (alnum || (char_i == cwc_pkg::CH_SQUOTE)) begin
      if (!st_i.in_run) begin
        nst.run_digit = cwc_pkg::is_digit(char_i);
      end
      nst.in_run = 1'b1;
    end else begin
      nst.in_run    = 1'b0;
      nst.run_digit = 1'b0;
    end
    nst.prev_alnum = alnum;

    // Assemble results; the last one carries the markers
    res0_o = '0;
    res1_o = '0;
    if (emit_sp) begin
      res0_o.ch       = cwc_pkg::CH_SPACE;
      res0_o.has_char = 1'b1;
      res1_o.ch       = char_i;
      res1_o.has_char = 1'b1;
      res1_o.run_last = 1'b1;
      res1_o.text_end = last_i;
      nres_o          = 2'd2;
    end else if (emit_ch) begin
      res0_o.ch       = char_i;
      res0_o.has_char = 1'b1;
      res0_o.run_last = 1'b1;
      res0_o.text_end = last_i;
      nres_o          = 2'd1;
    end else if (last_i) begin
      res0_o.run_last = 1'b1;
      res0_o.text_end = 1'b1;
      nres_o          = 2'd1;
    end else begin
      nres_o = 2'd0;
    end

    // A finished text starts the next one from reset
    st_o = last_i ? cwc_pkg::STATE_RST : nst;
  end

endmodule

FILE: hw/rtl/cwc_rbuf.sv
// Module: small result queue that takes up to two results per cycle and gives one.
`timescale 1ns / 1ps

module cwc_rbuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_n_i,
  input  cwc_pkg::cwc_res_t d0_i,
  input  cwc_pkg::cwc_res_t d1_i,
  output logic              room2_o,
  output logic              vld_o,
  input  logic              pop_i,
  output cwc_pkg::cwc_res_t q_o
);

  cwc_pkg::cwc_res_t                   mem [cwc_pkg::RBUF_DEPTH];
  logic [cwc_pkg::RBUF_AW-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [cwc_pkg::RBUF_AW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [cwc_pkg::RBUF_CW-1:0]         count_r, count_nxt;
  logic                                pop;

  assign pop     = pop_i && (count_r != '0);
  assign vld_o   = (count_r != '0);
  assign q_o     = mem[rd_ptr_r];
  assign room2_o = (count_r <= cwc_pkg::RBUF_CW'(cwc_pkg::RBUF_DEPTH - 2));

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + cwc_pkg::RBUF_AW'(push_n_i);
    rd_ptr_nxt = rd_ptr_r + cwc_pkg::RBUF_AW'(pop);
    count_nxt  = count_r + cwc_pkg::RBUF_CW'(push_n_i) - cwc_pkg::RBUF_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage writes: first result at the tail, second one after it
  always_ff @(posedge clk) begin
    if (push_n_i != 2'd0) begin
      mem[wr_ptr_r] <= d0_i;
    end
    if (push_n_i == 2'd2) begin
      mem[wr_ptr_r + cwc_pkg::RBUF_AW'(1)] <= d1_i;
    end
  end

endmodule

FILE: dv/tb_top.sv
// Testbench for code_whitespace_collapser: random and directed texts against a local scanner.
`timescale 1ns / 1ps

module tb_top;

  localparam int STALL_LIMIT = 2000;  // cycles with no transfer on either side
  localparam int TAIL_CYCLES = 16;
  localparam int PHASE_UNITS = 333;   // random units per idling phase

  // One pending input transfer; hold makes the driver wait for an empty scoreboard
  typedef struct {
    logic [15:0] ch;
    logic        last;
    logic        hold;
    int unsigned phase;
  } unit_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] char_in
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [15:0] char_out
  logic [1:0]  out_tuser;       // [0] has_char, [1] run_last
  logic        out_tlast;

  unit_item_t           src_units[$];
  cwc_pkg::cwc_res_t    expected_chars[$];
  cwc_pkg::cwc_state_t  scan = cwc_pkg::STATE_RST;
  unit_item_t           nxt_unit;
  cwc_pkg::cwc_res_t    want;
  logic        in_took = 1'b0;
  int unsigned cur_phase = 0;
  int unsigned fill_phase = 0;
  logic        hold_next = 1'b0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int unsigned send_idle_pct[3] = '{19, 56, 0};
  int unsigned recv_idle_pct[3] = '{56, 19, 0};

  always #2 clk = ~clk;

  code_whitespace_collapser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // ASCII character classes
  function automatic logic digit_unit(input logic [15:0] c);
    return c inside {[16'h0030:16'h0039]};
  endfunction

  function automatic logic alnum_unit(input logic [15:0] c);
    return digit_unit(c) || (c inside {[16'h0041:16'h005A], [16'h0061:16'h007A]});
  endfunction

  function automatic logic blank_unit(input logic [15:0] c);
    return (c == cwc_pkg::CH_SPACE) || (c inside {[16'h0009:16'h000D]});
  endfunction

  // Advance the scanner by one unit and queue the characters it emits
  task automatic collapse_unit(input logic [15:0] c, input logic fin);
    cwc_pkg::cwc_res_t emitted[$];
    logic              an;
    an = alnum_unit(c);
    // a tentative quote is settled by the unit after it
    if (scan.mode == cwc_pkg::LIT_TENT)
      scan.mode = an ? cwc_pkg::LIT_NONE : cwc_pkg::LIT_SINGLE;
    if (scan.mode == cwc_pkg::LIT_DOUBLE || scan.mode == cwc_pkg::LIT_SINGLE) begin
      emitted.push_back('{ch: c, has_char: 1'b1, run_last: 1'b0, text_end: 1'b0});
      if (scan.esc)
        scan.esc = 1'b0;
      else if (c == cwc_pkg::CH_BSLASH)
        scan.esc = !fin;
      else if (c == ((scan.mode == cwc_pkg::LIT_DOUBLE) ? cwc_pkg::CH_DQUOTE
                                                         : cwc_pkg::CH_SQUOTE))
        scan.mode = cwc_pkg::LIT_NONE;
    end else if (blank_unit(c)) begin
      scan.sp = 1'b1;
    end else begin
      if (scan.sp && scan.started)
        emitted.push_back('{ch: cwc_pkg::CH_SPACE, has_char: 1'b1, run_last: 1'b0,
                            text_end: 1'b0});
      scan.sp = 1'b0;
      if (c == cwc_pkg::CH_DQUOTE)
        scan.mode = cwc_pkg::LIT_DOUBLE;
      else if (c == cwc_pkg::CH_SQUOTE)
        scan.mode = (scan.prev_alnum && scan.run_digit && !fin) ? cwc_pkg::LIT_TENT
                                                                 : cwc_pkg::LIT_SINGLE;
      emitted.push_back('{ch: c, has_char: 1'b1, run_last: 1'b0, text_end: 1'b0});
    end
    if (emitted.size() > 0) scan.started = 1'b1;
    // word-run tracking sees every unit, literals included
    if (an || c == cwc_pkg::CH_SQUOTE) begin
      if (!scan.in_run) scan.run_digit = digit_unit(c);
      scan.in_run = 1'b1;
    end else begin
      scan.in_run    = 1'b0;
      scan.run_digit = 1'b0;
    end
    scan.prev_alnum = an;
    // end of text with nothing emitted still produces a marker
    if (fin && emitted.size() == 0)
      emitted.push_back('{ch: '0, has_char: 1'b0, run_last: 1'b0, text_end: 1'b0});
    emitted[emitted.size()-1].run_last = 1'b1;
    if (fin) emitted[emitted.size()-1].text_end = 1'b1;
    foreach (emitted[i]) expected_chars.push_back(emitted[i]);
    if (fin) scan = cwc_pkg::STATE_RST;
  endtask

  // Stimulus helpers
  task automatic add_unit(input logic [15:0] c, input logic fin);
    src_units.push_back('{ch: c, last: fin, hold: hold_next, phase: fill_phase});
    hold_next = 1'b0;
  endtask

  function automatic logic [15:0] rand_alnum();
    int unsigned r;
    r = $urandom_range(0, 61);
    if (r < 10) return 16'(16'h0030 + r);
    if (r < 36) return 16'(16'h0041 + r - 10);
    return 16'(16'h0061 + r - 36);
  endfunction

  function automatic logic [15:0] rand_blank();
    int unsigned r;
    r = $urandom_range(0, 5);
    return (r == 5) ? cwc_pkg::CH_SPACE : 16'(16'h0009 + r);
  endfunction

  // One random text built from tokens; mostly well formed, some noise
  task automatic add_text();
    int unsigned ntok, n;
    ntok = $urandom_range(1, 8);
    for (int t = 0; t < ntok; t++) begin
      case ($urandom_range(0, 9)) inside
        0, 1: begin  // identifier or plain word
          n = $urandom_range(1, 6);
          repeat (n) add_unit(rand_alnum(), 1'b0);
        end
        2: begin  // number with digit separators, sometimes broken
          add_unit(16'(16'h0030 + $urandom_range(0, 9)), 1'b0);
          n = $urandom_range(1, 3);
          repeat (n) begin
            add_unit(cwc_pkg::CH_SQUOTE, 1'b0);
            repeat ($urandom_range(1, 3)) add_unit(rand_alnum(), 1'b0);
          end
          if ($urandom_range(0, 3) == 0) add_unit(cwc_pkg::CH_SQUOTE, 1'b0);
        end
        3: begin  // string literal with escapes, sometimes unclosed
          add_unit(cwc_pkg::CH_DQUOTE, 1'b0);
          n = $urandom_range(0, 6);
          repeat (n) begin
            if ($urandom_range(0, 4) == 0) add_unit(cwc_pkg::CH_BSLASH, 1'b0);
            add_unit(16'($urandom_range(16'h0020, 16'h007E)), 1'b0);
          end
          if ($urandom_range(0, 7) != 0) add_unit(cwc_pkg::CH_DQUOTE, 1'b0);
        end
        4: begin  // character literal
          add_unit(cwc_pkg::CH_SQUOTE, 1'b0);
          if ($urandom_range(0, 2) == 0) add_unit(cwc_pkg::CH_BSLASH, 1'b0);
          add_unit(16'($urandom_range(16'h0020, 16'h007E)), 1'b0);
          add_unit(cwc_pkg::CH_SQUOTE, 1'b0);
        end
        5, 6: begin  // whitespace run
          n = $urandom_range(1, 4);
          repeat (n) add_unit(rand_blank(), 1'b0);
        end
        7: add_unit(16'($urandom_range(16'h0021, 16'h007E)), 1'b0);
        default: begin  // noise over the whole unit range or the ASCII range
          if ($urandom_range(0, 1) == 0)
            add_unit(16'($urandom_range(0, 16'hFFFF)), 1'b0);
          else
            add_unit(16'($urandom_range(0, 16'h007F)), 1'b0);
        end
      endcase
    end
    src_units[src_units.size()-1].last = 1'b1;
  endtask

  // Input driver: new transfer on the falling edge once the previous one was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (src_units.size() > 0 && (!src_units[0].hold || expected_chars.size() == 0) &&
          $urandom_range(0, 99) >= send_idle_pct[src_units[0].phase]) begin
        nxt_unit = src_units.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= nxt_unit.ch;
        in_tlast  <= nxt_unit.last;
        cur_phase <= nxt_unit.phase;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side backpressure
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 99) >= recv_idle_pct[cur_phase]);
  end

  // Monitor: check result transfers, then predict from input transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected result transfer: char_out %h has_char %b",
                 out_tdata, out_tuser[0]);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          if (out_tdata !== want.ch) begin
            $error("char_out: expected %h, got %h", want.ch, out_tdata);
            mismatches++;
          end
          if (out_tuser[0] !== want.has_char) begin
            $error("has_char: expected %b, got %b", want.has_char, out_tuser[0]);
            mismatches++;
          end
          if (out_tuser[1] !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, out_tuser[1]);
            mismatches++;
          end
          if (out_tlast !== want.text_end) begin
            $error("text_end: expected %b, got %b", want.text_end, out_tlast);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) collapse_unit(in_tdata, in_tlast);
      in_took <= in_tvalid && in_tready;
    end
  end

  // Watchdog on transfer activity
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    // Directed: whitespace trimming and collapsing, separators, escapes, wide units
    add_unit(cwc_pkg::CH_SPACE, 1'b0);
    add_unit(16'h0009, 1'b0);
    add_unit(16'h0061, 1'b0);            // a
    add_unit(cwc_pkg::CH_SPACE, 1'b0);
    add_unit(16'h000D, 1'b0);
    add_unit(16'h0031, 1'b0);            // 1
    add_unit(cwc_pkg::CH_SQUOTE, 1'b0);  // separator candidate
    add_unit(16'h0030, 1'b0);            // 0 confirms separator
    add_unit(16'h000B, 1'b0);
    add_unit(cwc_pkg::CH_DQUOTE, 1'b0);
    add_unit(cwc_pkg::CH_BSLASH, 1'b0);
    add_unit(cwc_pkg::CH_DQUOTE, 1'b0);  // escaped
    add_unit(cwc_pkg::CH_DQUOTE, 1'b0);  // closes the string
    add_unit(16'hFFFF, 1'b0);
    add_unit(16'h0080, 1'b0);
    add_unit(cwc_pkg::CH_SPACE, 1'b1);   // trailing blank ends the text bare
    // tentative quote that turns into a character literal
    add_unit(16'h0039, 1'b0);            // 9
    add_unit(cwc_pkg::CH_SQUOTE, 1'b0);
    add_unit(16'h002D, 1'b0);            // -
    add_unit(cwc_pkg::CH_SQUOTE, 1'b0);  // closes it
    add_unit(cwc_pkg::CH_SQUOTE, 1'b0);  // opens a new one
    add_unit(cwc_pkg::CH_BSLASH, 1'b1);  // backslash at end escapes nothing
    // quote at end of text after a digit run
    add_unit(16'h0037, 1'b0);            // 7
    add_unit(cwc_pkg::CH_SQUOTE, 1'b1);
    add_unit(16'h000C, 1'b1);            // text of one blank

    // Random texts in three idling phases, each opened after a full drain
    for (int p = 0; p < 3; p++) begin
      fill_phase = p;
      hold_next  = 1'b1;
      while (src_units.size() < 25 + (p + 1) * PHASE_UNITS) add_text();
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (src_units.size() == 0 && !in_tvalid);
    wait (expected_chars.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_chars.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
